// ===== rtl/oanav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanav_pkg
// Shared types, widths and constants for the obstacle-avoiding navigation core.
// ----------------------------------------------------------------------------
package oanav_pkg;

    // Field widths of the stream payload.
    localparam int RANGE_BITS = 10;
    localparam int TIME_BITS  = 32;
    localparam int DRIVE_W    = 9;
    localparam int MODE_W     = 3;

    // Configuration register widths.
    localparam int DIST_W     = 10;
    localparam int SPEED_W    = 8;
    localparam int DUR_W      = 16;
    localparam int LIMIT_W    = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_W        = 2 * RANGE_BITS + TIME_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * DRIVE_W + MODE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Common width for comparing a range reading against a distance register.
    localparam int CMP_W = (RANGE_BITS > DIST_W) ? RANGE_BITS : DIST_W;

    // The approach-speed quotient is below cruise_speed, so it has SPEED_W bits.
    localparam int DIV_STEPS = SPEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // floor(x / 5) == (x * 205) >> 10 for every x below 1024.
    localparam int RECIP5       = 205;
    localparam int RECIP5_SHIFT = 10;

    localparam int HIT_MAX        = 15;
    localparam int STUCK_RETRY_MS = 1000;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_OBST_DIST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAFE_DIST  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CRUISE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPIN       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_TIME  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REV_TIME   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_STUCK_LIM  = 3'd6;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE  = 3'd0,
        MODE_FWD   = 3'd1,
        MODE_OBST  = 3'd2,
        MODE_LEFT  = 3'd3,
        MODE_RIGHT = 3'd4,
        MODE_BACK  = 3'd5,
        MODE_STUCK = 3'd6
    } nav_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
    } dp_sts_t;

endpackage

// ===== rtl/oanav_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanav_ctrl
// Sequencer for one navigation step: capture, evaluate, divide, commit.
// ----------------------------------------------------------------------------
module oanav_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output oanav_pkg::dp_cmd_t cmd,
    input  oanav_pkg::dp_sts_t sts
);
    import oanav_pkg::*;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT
    } ctrl_state_t;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    ctrl_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    // The result registers may be reloaded when empty or being emptied now.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_WAIT);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_WAIT:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.need_div)
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/oanav_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanav_dp
// Navigation datapath: configuration, step state, approach-speed divider.
// ----------------------------------------------------------------------------
module oanav_dp
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [oanav_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [oanav_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic [oanav_pkg::IN_TDATA_W-1:0]        in_data,
    output logic [oanav_pkg::OUT_TDATA_W-1:0]       out_data,
    input  oanav_pkg::dp_cmd_t                      cmd,
    output oanav_pkg::dp_sts_t                      sts
);
    import oanav_pkg::*;

    localparam int PROD_W = SPEED_W + RANGE_BITS;
    localparam int FL_W   = CMP_W + 3;
    localparam int R5_W   = SPEED_W + 1 + RECIP5_SHIFT;

    // Configuration registers.
    logic [DIST_W-1:0]  obst_dist_reg, safe_dist_reg;
    logic [SPEED_W-1:0] cruise_reg, spin_reg;
    logic [DUR_W-1:0]   turn_time_reg, rev_time_reg;
    logic [LIMIT_W-1:0] stuck_lim_reg;

    // Captured input item.
    logic [RANGE_BITS-1:0] front_reg, rear_reg;
    logic [TIME_BITS-1:0]  now_reg;

    // Navigation state; the mode and last speeds also form the result.
    nav_mode_t                  mode_reg, mode_next;
    logic [TIME_BITS-1:0]       start_reg, start_next;
    logic                       trn_reg, trn_next;
    logic [LIMIT_W-1:0]         hit_reg, hit_next;
    logic signed [DRIVE_W-1:0]  left_reg, left_next, right_reg, right_next;

    // Restoring divider.
    logic [DIST_W-1:0]  rem_reg;
    logic [SPEED_W-1:0] lo_reg, quo_reg;
    logic [PROD_W-1:0]  product;
    logic [DIST_W:0]    trial;
    logic               trial_ge;

    logic [CMP_W-1:0]           front_c, rear_c, obst_c, safe_c;
    logic                       f_obst, f_close, r_clear, use_floor;
    logic [TIME_BITS-1:0]       elapsed;
    logic                       turn_done, rev_done, stuck_done;
    logic [LIMIT_W-1:0]         hit_inc;
    logic [R5_W-1:0]            floor_prod;
    logic [SPEED_W-1:0]         approach;
    logic signed [DRIVE_W-1:0]  cruise_s, spin_s, back_s, approach_s;
    nav_mode_t                  target;

    assign front_c = CMP_W'(front_reg);
    assign rear_c  = CMP_W'(rear_reg);
    assign obst_c  = CMP_W'(obst_dist_reg);
    assign safe_c  = CMP_W'(safe_dist_reg);

    assign f_obst  = (front_c != '0) && (front_c < obst_c);
    assign f_close = (front_c != '0) && (front_c < safe_c);
    assign r_clear = (rear_c == '0) || (rear_c > obst_c);
    // Factor floor of 0.4: 5 * front < 2 * safe.
    assign use_floor = ((FL_W'(front_c) << 2) + FL_W'(front_c)) < (FL_W'(safe_c) << 1);

    assign sts.need_div = (mode_reg == MODE_FWD) && !f_obst && f_close && !use_floor;

    assign elapsed    = now_reg - start_reg;
    assign turn_done  = elapsed >= TIME_BITS'(turn_time_reg);
    assign rev_done   = elapsed >= TIME_BITS'(rev_time_reg);
    assign stuck_done = elapsed >= TIME_BITS'(STUCK_RETRY_MS);

    assign hit_inc = (hit_reg == LIMIT_W'(HIT_MAX)) ? hit_reg : hit_reg + 1'b1;

    assign floor_prod = R5_W'({cruise_reg, 1'b0}) * R5_W'(RECIP5);
    assign approach   = use_floor ? SPEED_W'(floor_prod >> RECIP5_SHIFT) : quo_reg;

    assign cruise_s   = $signed({1'b0, cruise_reg});
    assign spin_s     = $signed({1'b0, spin_reg});
    assign back_s     = -$signed({2'b00, cruise_reg[SPEED_W-1:1]});
    assign approach_s = $signed({1'b0, approach});

    assign product  = PROD_W'(cruise_reg) * PROD_W'(front_reg);
    assign trial    = {rem_reg, lo_reg[SPEED_W-1]};
    assign trial_ge = trial >= (DIST_W+1)'(safe_dist_reg);

    // Direction chosen from the alternation flag before it toggles.
    assign target = trn_reg ? MODE_LEFT : MODE_RIGHT;

    always_comb
    begin
        mode_next  = mode_reg;
        trn_next   = trn_reg;
        hit_next   = hit_reg;
        left_next  = left_reg;
        right_next = right_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                left_next  = '0;
                right_next = '0;
                mode_next  = MODE_FWD;
            end
            MODE_FWD:
            begin
                if (f_obst)
                begin
                    hit_next  = hit_inc;
                    mode_next = (hit_inc >= stuck_lim_reg) ? MODE_BACK : MODE_OBST;
                end
                else if (f_close)
                begin
                    left_next  = approach_s;
                    right_next = approach_s;
                end
                else
                begin
                    left_next  = cruise_s;
                    right_next = cruise_s;
                    hit_next   = '0;
                end
            end
            MODE_OBST:
            begin
                left_next  = '0;
                right_next = '0;
                trn_next   = !trn_reg;
                mode_next  = target;
            end
            MODE_LEFT:
            begin
                left_next  = -spin_s;
                right_next = spin_s;
                if (turn_done)
                begin
                    mode_next = MODE_FWD;
                end
            end
            MODE_RIGHT:
            begin
                left_next  = spin_s;
                right_next = -spin_s;
                if (turn_done)
                begin
                    mode_next = MODE_FWD;
                end
            end
            MODE_BACK:
            begin
                if (r_clear)
                begin
                    left_next  = back_s;
                    right_next = back_s;
                    if (rev_done)
                    begin
                        hit_next  = '0;
                        trn_next  = !trn_reg;
                        mode_next = target;
                    end
                end
                else
                begin
                    mode_next = MODE_STUCK;
                end
            end
            MODE_STUCK:
            begin
                left_next  = '0;
                right_next = '0;
                if (stuck_done)
                begin
                    hit_next  = '0;
                    mode_next = MODE_FWD;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
        // The maneuver timer restarts only when the mode actually changes.
        start_next = (mode_next != mode_reg) ? now_reg : start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obst_dist_reg <= DIST_W'(20);
            safe_dist_reg <= DIST_W'(40);
            cruise_reg    <= SPEED_W'(200);
            spin_reg      <= SPEED_W'(150);
            turn_time_reg <= DUR_W'(400);
            rev_time_reg  <= DUR_W'(300);
            stuck_lim_reg <= LIMIT_W'(3);
            mode_reg      <= MODE_IDLE;
            start_reg     <= '0;
            trn_reg       <= 1'b1;
            hit_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_OBST_DIST: obst_dist_reg <= cfg_wdata[DIST_W-1:0];
                    REG_SAFE_DIST: safe_dist_reg <= cfg_wdata[DIST_W-1:0];
                    REG_CRUISE:    cruise_reg    <= cfg_wdata[SPEED_W-1:0];
                    REG_SPIN:      spin_reg      <= cfg_wdata[SPEED_W-1:0];
                    REG_TURN_TIME: turn_time_reg <= cfg_wdata[DUR_W-1:0];
                    REG_REV_TIME:  rev_time_reg  <= cfg_wdata[DUR_W-1:0];
                    REG_STUCK_LIM: stuck_lim_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                trn_reg   <= trn_next;
                hit_reg   <= hit_next;
                left_reg  <= left_next;
                right_reg <= right_next;
            end
        end
    end

    // Payload registers: input capture and divider.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            front_reg <= in_data[RANGE_BITS-1:0];
            rear_reg  <= in_data[2*RANGE_BITS-1:RANGE_BITS];
            now_reg   <= in_data[IN_W-1:2*RANGE_BITS];
        end
        if (cmd.div_load)
        begin
            // front < safe, so the high part of the product is below safe.
            rem_reg <= DIST_W'(product[PROD_W-1:SPEED_W]);
            lo_reg  <= product[SPEED_W-1:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? DIST_W'(trial - (DIST_W+1)'(safe_dist_reg))
                                : DIST_W'(trial);
            lo_reg  <= {lo_reg[SPEED_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SPEED_W-2:0], trial_ge};
        end
    end

    assign out_data = OUT_TDATA_W'({mode_reg, right_reg, left_reg});

endmodule

// ===== rtl/obstacle_avoid_nav_fsm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoid_nav_fsm_core
// Obstacle-avoiding rover navigation: range readings in, motor speeds out.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents (lowest bits first)
// s_*       in         front_range, rear_range, now_ms
// m_*       out        left_drive, right_drive, mode
// cfg_*     in         register index and write data, no read-back
//
// An item that needs no divide is captured from the transfer, evaluated
// and committed, in that order. In forward mode with the
// front reading between the 0.4 floor and safe_distance, an 8-step
// restoring divider computes cruise*front/safe, one quotient bit per cycle,
// between evaluation and commit. The next transfer is taken as soon as the
// previous step commits, even while its result is still waiting on m_tready;
// the commit of the following step then holds until that result is taken.
// Reset loads the register defaults and puts the rover in idle mode.
// The navigation registers themselves hold the offered result.
module obstacle_avoid_nav_fsm_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // front_range[9:0], rear_range[19:10], now_ms[51:20], zero fill
    input  logic [oanav_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_drive[8:0], right_drive[17:9], mode[20:18], zero fill
    output logic [oanav_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_we,
    input  logic [oanav_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [oanav_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import oanav_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller sequences each step and owns both handshakes.
    oanav_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds configuration, navigation state and the divider.
    oanav_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
